>>> design/assert_macros.svh
// assertion macros used by the output channel checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define DNLE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// clocked assertion that is also checked during reset
`define DNLE_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: assertion failed");

`endif

>>> design/dnle_pkg.sv
// shared types and constants of the dns name label encoder
package dnle_pkg;

  localparam int CHAR_W        = 8;
  localparam int CAP_W         = 11;
  localparam int LEN_W         = 11;
  localparam int LABEL_MAX_DEF = 62;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 2;

  localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'd46;
  localparam logic [CHAR_W-1:0] TERM_BYTE = 8'd0;
  localparam logic [CAP_W-1:0]  CAP_RESET = 11'd512;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHR,
    ST_TERM
  } dnle_state_t;

  typedef struct packed {
    logic store_char;
    logic drop_label;
    logic load_len;
    logic load_chr;
    logic finish_label;
    logic load_term;
    logic clear_name;
  } dnle_cmd_t;

  typedef struct packed {
    logic is_end;
    logic is_dot;
    logic stopped;
    logic cap_zero;
    logic label_empty;
    logic label_fits;
    logic last_chr;
    logic out_free;
  } dnle_status_t;

endpackage

>>> design/dnle_if.sv
// valid/ready channel interfaces for characters in and encoded words out
interface dnle_in_if;
  import dnle_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              end_of_name;

  modport source (output valid, output ch, output end_of_name, input ready);
  modport sink   (input valid, input ch, input end_of_name, output ready);
endinterface

interface dnle_out_if;
  import dnle_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_byte;
  logic              name_done;
  logic [LEN_W-1:0]  encoded_length;

  modport source (output valid, output out_byte, output name_done, output encoded_length,
                  input ready);
  modport sink   (input valid, input out_byte, input name_done, input encoded_length,
                  output ready);
endinterface

>>> design/dns_name_label_encoder.sv
// top level: dns name label encoder with apb capacity register
// a plain character is taken while the controller is idle; a dot or end item
// is taken too, and the input is then held while the length word and label
// characters of a flushed label are loaded (one label ram read each) and, on
// an end item, while the terminator word is loaded
// rst is synchronous: clears counters and state, capacity returns to 512
module dns_name_label_encoder #(
  parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  dnle_in_if.sink                          chars,
  dnle_out_if.source                       codes,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dnle_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dnle_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dnle_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import dnle_pkg::*;

  logic [CAP_W-1:0] out_capacity;
  logic             cfg_write;
  logic             cap_sel;
  dnle_cmd_t        cmd;
  dnle_status_t     status;

  // apb access: one register at byte address 0, no wait states
  assign pready    = 1'b1;
  assign cap_sel   = (paddr == '0);
  assign cfg_write = psel && penable && pwrite && pready && cap_sel;

  // reads of the capacity word, zero elsewhere in the byte range
  assign prdata = cap_sel ? APB_DATA_W'(out_capacity) : '0;

  // writes to the other byte offsets are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_write) begin
      out_capacity <= pwdata[CAP_W-1:0];
    end
  end

  // controller decides per word what the datapath does
  dnle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (chars.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath holds the label buffer, counters and the output word register,
  // so the next character is taken while a finished word waits downstream
  dnle_dp #(
    .LABEL_MAX (LABEL_MAX)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cap            (out_capacity),
    .ch             (chars.ch),
    .end_of_name    (chars.end_of_name),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (codes.valid),
    .out_ready      (codes.ready),
    .out_byte       (codes.out_byte),
    .name_done      (codes.name_done),
    .encoded_length (codes.encoded_length)
  );

endmodule

>>> design/dnle_ram.sv
// generic single write port ram with registered read
module dnle_ram #(
  parameter int WIDTH = dnle_pkg::CHAR_W,
  parameter int DEPTH = dnle_pkg::LABEL_MAX_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/dnle_dp.sv
// datapath: label buffer, name counters and output word register
module dnle_dp #(
  parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dnle_pkg::CAP_W-1:0]   cap,
  input  logic [dnle_pkg::CHAR_W-1:0]  ch,
  input  logic                         end_of_name,
  input  dnle_pkg::dnle_cmd_t          cmd,
  output dnle_pkg::dnle_status_t       status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dnle_pkg::CHAR_W-1:0]  out_byte,
  output logic                         name_done,
  output logic [dnle_pkg::LEN_W-1:0]   encoded_length
);
  import dnle_pkg::*;

  localparam int CW = $clog2(LABEL_MAX + 2);
  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int SW = LEN_W + 1;
  localparam logic [CW-1:0] COUNT_MAX  = CW'(LABEL_MAX);
  localparam logic [CW-1:0] COUNT_OVER = CW'(LABEL_MAX + 1);

  logic [CW-1:0]     label_count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     idx_inc;
  logic [LEN_W-1:0]  written_count;
  logic              stopped;
  logic [SW-1:0]     need;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  // bytes in use after this label plus the terminator
  assign need    = SW'(written_count) + SW'(label_count) + SW'(2);
  assign idx_inc = idx + CW'(1);

  assign status.is_end      = end_of_name;
  assign status.is_dot      = (ch == DOT_CHAR);
  assign status.stopped     = stopped;
  assign status.cap_zero    = (cap == '0);
  assign status.label_empty = (label_count == '0);
  assign status.label_fits  = (label_count <= COUNT_MAX) && (need <= SW'(cap));
  assign status.last_chr    = (idx_inc == label_count);
  assign status.out_free    = !out_valid || out_ready;

  assign ram_we    = cmd.store_char && (label_count < COUNT_MAX);
  assign ram_re    = cmd.load_len || (cmd.load_chr && !status.last_chr);
  assign ram_raddr = cmd.load_len ? '0 : idx_inc[AW-1:0];

  dnle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LABEL_MAX)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (label_count[AW-1:0]),
    .wdata (ch),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      label_count   <= '0;
      written_count <= '0;
      stopped       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.store_char) begin
        label_count <= (label_count < COUNT_MAX) ? label_count + CW'(1) : COUNT_OVER;
      end
      if (cmd.drop_label) begin
        label_count <= '0;
        if (!status.cap_zero) begin
          stopped <= 1'b1;
        end
      end
      if (cmd.load_len) begin
        written_count <= written_count + LEN_W'(1) + LEN_W'(label_count);
      end
      if (cmd.finish_label) begin
        label_count <= '0;
      end
      if (cmd.load_term || cmd.clear_name) begin
        label_count   <= '0;
        written_count <= '0;
        stopped       <= 1'b0;
      end
      if (cmd.load_len || cmd.load_chr || cmd.load_term) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_len) begin
      idx <= '0;
    end else if (cmd.load_chr) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_len) begin
      out_byte       <= CHAR_W'(label_count);
      name_done      <= 1'b0;
      encoded_length <= '0;
    end else if (cmd.load_chr) begin
      out_byte       <= ram_rdata;
      name_done      <= 1'b0;
      encoded_length <= '0;
    end else if (cmd.load_term) begin
      out_byte       <= TERM_BYTE;
      name_done      <= 1'b1;
      encoded_length <= written_count + LEN_W'(1);
    end
  end

endmodule

>>> design/dnle_ctrl.sv
// controller: sequences label emission and the terminator word
module dnle_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dnle_pkg::dnle_status_t status,
  output dnle_pkg::dnle_cmd_t    cmd
);
  import dnle_pkg::*;

  dnle_state_t state;
  dnle_state_t state_next;
  logic        end_pending;
  logic        end_pending_next;
  logic        flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      end_pending <= 1'b0;
    end else begin
      state       <= state_next;
      end_pending <= end_pending_next;
    end
  end

  // an end item flushes only a nonempty label, a dot always flushes
  assign flush = status.is_end ? !status.label_empty : 1'b1;

  always_comb begin
    state_next       = state;
    end_pending_next = end_pending;
    in_ready         = 1'b0;
    cmd              = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          end_pending_next = status.is_end;
          priority if (status.is_end || (status.is_dot && !status.stopped)) begin
            if (flush && !status.cap_zero && !status.stopped && status.label_fits) begin
              state_next = ST_LEN;
            end else if (status.is_end && status.cap_zero) begin
              // capacity zero: the name closes with no word at all
              cmd.clear_name = 1'b1;
            end else begin
              cmd.drop_label = flush;
              if (status.is_end) begin
                state_next = ST_TERM;
              end
            end
          end else if (!status.is_dot && !status.stopped) begin
            cmd.store_char = 1'b1;
          end else begin
            // stopped: characters and dots are dropped until the end item
          end
        end
      end
      ST_LEN: begin
        if (status.out_free) begin
          cmd.load_len = 1'b1;
          if (status.label_empty) begin
            cmd.finish_label = 1'b1;
            state_next       = end_pending ? ST_TERM : ST_IDLE;
          end else begin
            state_next = ST_CHR;
          end
        end
      end
      ST_CHR: begin
        if (status.out_free) begin
          cmd.load_chr = 1'b1;
          if (status.last_chr) begin
            cmd.finish_label = 1'b1;
            state_next       = end_pending ? ST_TERM : ST_IDLE;
          end
        end
      end
      ST_TERM: begin
        if (status.out_free) begin
          cmd.load_term = 1'b1;
          state_next    = ST_IDLE;
        end
      end
    endcase
  end

endmodule

>>> design/dnle_chk.sv
// port level checker for the encoder output channel, bound to the top level
`include "assert_macros.svh"

module dnle_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dnle_pkg::CHAR_W-1:0] out_byte,
  input logic                        name_done,
  input logic [dnle_pkg::LEN_W-1:0]  encoded_length
);
  import dnle_pkg::*;

  // a word offered and not taken is still offered next cycle
  `DNLE_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)

  // terminator is a zero byte with a nonzero total length
  `DNLE_ASSERT(a_term_word, clk, rst, out_valid && name_done |-> out_byte == TERM_BYTE && encoded_length != '0)

  // length field stays zero on label words
  `DNLE_ASSERT(a_len_on_term, clk, rst, out_valid && !name_done |-> encoded_length == '0)

  // nothing is offered right after reset
  `DNLE_ASSERT_NR(a_reset_idle, clk, rst |=> !out_valid)

endmodule

bind dns_name_label_encoder dnle_chk u_dnle_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (codes.valid),
  .out_ready      (codes.ready),
  .out_byte       (codes.out_byte),
  .name_done      (codes.name_done),
  .encoded_length (codes.encoded_length)
);

>>> test/tb_top.sv
// self-checking testbench for the dns name label encoder: labels in, coded words out
module tb_top;
  import dnle_pkg::*;

  localparam int LABEL_MAX    = LABEL_MAX_DEF;
  localparam int DRAIN_CYCLES = 80;   // longest label plus length and terminator words
  localparam int HOLD_CYCLES  = 300;  // receiver hold-off used to back the block up
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR = '0;

  // one coded word as it leaves the block
  typedef struct packed {
    logic [CHAR_W-1:0] out_byte;
    logic              name_done;
    logic [LEN_W-1:0]  encoded_length;
  } code_word_t;

  // predicts the coded words of each name and checks them in order
  class label_coder;
    logic [CAP_W-1:0]  capacity;
    logic [CHAR_W-1:0] label_buf [LABEL_MAX];
    logic [6:0]        label_len;   // LABEL_MAX + 1 marks a label that outgrew the buffer
    logic [LEN_W-1:0]  bytes_out;
    bit                halted;      // a label did not fit, rest of the name is dropped
    code_word_t        pending_codes[$];
    int                failures;
    int                words_seen;
    int                names_closed;

    function new();
      capacity     = CAP_RESET;
      label_len    = '0;
      bytes_out    = '0;
      halted       = 1'b0;
      failures     = 0;
      words_seen   = 0;
      names_closed = 0;
    endfunction

    function void push_code(input logic [CHAR_W-1:0] b, input logic d,
                            input logic [LEN_W-1:0] l);
      code_word_t w;
      w.out_byte       = b;
      w.name_done      = d;
      w.encoded_length = l;
      pending_codes.push_back(w);
    endfunction

    // length word then the characters, if the label still fits before the terminator
    function void flush_label();
      int i;
      if (capacity == '0 || halted) begin
        label_len = '0;
        return;
      end
      if (label_len > LABEL_MAX ||
          int'(bytes_out) + 1 + int'(label_len) > int'(capacity) - 1) begin
        halted    = 1'b1;
        label_len = '0;
        return;
      end
      push_code(CHAR_W'(label_len), 1'b0, '0);
      for (i = 0; i < int'(label_len); i++)
        push_code(label_buf[i], 1'b0, '0);
      bytes_out = bytes_out + LEN_W'(1) + LEN_W'(label_len);
      label_len = '0;
    endfunction

    function void accept_char(input logic [CHAR_W-1:0] c, input logic eon);
      if (eon) begin
        if (label_len != '0)
          flush_label();
        // capacity zero closes the name silently
        if (capacity != '0) begin
          bytes_out = bytes_out + LEN_W'(1);
          push_code(TERM_BYTE, 1'b1, bytes_out);
        end
        label_len = '0;
        bytes_out = '0;
        halted    = 1'b0;
        return;
      end
      if (halted)
        return;
      if (c == DOT_CHAR) begin
        flush_label();
        return;
      end
      if (label_len < LABEL_MAX) begin
        label_buf[label_len] = c;
        label_len = label_len + 7'd1;
      end else begin
        label_len = 7'(LABEL_MAX + 1);
      end
    endfunction

    function void report(input string msg);
      failures++;
      if (failures <= 10)
        $display("ERROR: %s", msg);
    endfunction

    function void check_code(input code_word_t got);
      code_word_t want;
      words_seen++;
      if (pending_codes.size() == 0) begin
        report($sformatf("unexpected word byte=%0d done=%0b len=%0d",
                         got.out_byte, got.name_done, got.encoded_length));
        return;
      end
      want = pending_codes.pop_front();
      if (got.out_byte !== want.out_byte || got.name_done !== want.name_done ||
          got.encoded_length !== want.encoded_length)
        report($sformatf("word %0d: expected byte=%0d done=%0b len=%0d, got byte=%0d done=%0b len=%0d",
                         words_seen, want.out_byte, want.name_done, want.encoded_length,
                         got.out_byte, got.name_done, got.encoded_length));
      if (got.name_done === 1'b1)
        names_closed++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dnle_in_if  char_bus ();
  dnle_out_if code_bus ();

  label_coder coder;
  int         items_sent    = 0;
  int         send_idle_pct = 25;
  int         recv_idle_pct = 57;
  logic       hold_on;
  event       hold_kick;

  dns_name_label_encoder u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_bus),
    .codes   (code_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: check every accepted word, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && code_bus.valid && code_bus.ready)
      coder.check_code({code_bus.out_byte, code_bus.name_done, code_bus.encoded_length});
    code_bus.ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off, counted here, while the sender keeps offering characters
  initial begin
    hold_on = 1'b0;
    @(hold_kick);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // apb write of the capacity register: setup cycle then access cycle
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    coder.capacity = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offers one character or end mark; valid stays up after acceptance unless a gap follows
  task automatic send_item(input logic [CHAR_W-1:0] c, input logic eon);
    while ($urandom_range(99) < send_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid       <= 1'b1;
    char_bus.ch          <= c;
    char_bus.end_of_name <= eon;
    do @(posedge clk); while (!char_bus.ready);
    coder.accept_char(c, eon);
    items_sent++;
  endtask

  function automatic logic [CHAR_W-1:0] label_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom); while (c == DOT_CHAR);
    return c;
  endfunction

  // well-formed name: labels joined by dots, sometimes a trailing dot, then the end mark
  task automatic send_name(input int min_len, input int max_len, input int n_labels,
                           input bit oversize);
    int big;
    int len;
    int i;
    big = oversize ? $urandom_range(0, n_labels - 1) : -1;
    for (i = 0; i < n_labels; i++) begin
      len = (i == big) ? $urandom_range(LABEL_MAX + 1, LABEL_MAX + 4)
                       : $urandom_range(min_len, max_len);
      repeat (len) send_item(label_char(), 1'b0);
      if (i < n_labels - 1 || $urandom_range(3) == 0)
        send_item(DOT_CHAR, 1'b0);
    end
    send_item(CHAR_W'($urandom), 1'b1);
  endtask

  // mostly well-formed names, some noise with stray dots
  task automatic random_name(input int max_len);
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(0, 8))
        send_item(($urandom_range(4) == 0) ? DOT_CHAR : CHAR_W'($urandom), 1'b0);
      send_item(CHAR_W'($urandom), 1'b1);
    end else begin
      send_name(0, max_len, $urandom_range(1, 4), 1'b0);
    end
  endtask

  // block idle: all words back, then time for any silent work still in flight
  task automatic settle();
    char_bus.valid <= 1'b0;
    while (coder.pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    int r;
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    char_bus.valid       = 1'b0;
    char_bus.ch          = '0;
    char_bus.end_of_name = 1'b0;
    code_bus.ready       = 1'b0;
    coder = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme characters, empty label between dots, trailing dot
    write_capacity(11'd1024);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item(8'd255, 1'b1);
    // capacity changed in the middle of a name
    send_item("x", 1'b0);
    send_item("y", 1'b0);
    settle();
    write_capacity(11'd4);
    send_item(8'd0, 1'b1);
    settle();
    // capacity zero: nothing comes out, not even the terminator
    write_capacity(11'd0);
    send_item("a", 1'b0);
    send_item(8'd0, 1'b1);
    settle();
    // exact fit, then a label one too long and everything after it dropped
    write_capacity(11'd5);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item("c", 1'b0);
    send_item(8'd0, 1'b1);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item("c", 1'b0);
    send_item("d", 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item("e", 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item(8'd0, 1'b1);
    settle();
    // capacity one: only the terminator ever fits
    write_capacity(11'd1);
    send_item(8'd0, 1'b1);
    settle();

    // random, top of the register range, with one label longer than the buffer
    write_capacity(11'd2047);
    send_name(0, 6, 2, 1'b1);
    target = items_sent + 10;
    while (items_sent < target) random_name(6);
    settle();

    // tight capacities so labels stop fitting, sender now idles more than receiver
    send_idle_pct = 57;
    recv_idle_pct <= 25;
    for (r = 0; r < 2; r++) begin
      write_capacity(CAP_W'($urandom_range(6, 40)));
      target = items_sent + 6;
      while (items_sent < target) random_name(6);
      settle();
    end
    write_capacity(11'd0);
    random_name(6);
    settle();

    // no idling; receiver holds off while the names back the block up
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_capacity(CAP_W'($urandom_range(64, 1024)));
    -> hold_kick;
    send_name(4, 8, 2, 1'b0);
    target = items_sent + 6;
    while (items_sent < target) random_name(6);
    settle();
    write_capacity(CAP_RESET);
    random_name(6);
    settle();

    $display("run covered %0d characters and end marks, capacities 0 to 2047, long labels",
             items_sent);
    $display("%0d coded words and %0d names checked, %0d failures",
             coder.words_seen, coder.names_closed, coder.failures);
    if (coder.failures == 0 && coder.pending_codes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #1_500_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/dnle_pkg.sv
design/dnle_if.sv
design/dnle_ram.sv
design/dnle_dp.sv
design/dnle_ctrl.sv
design/dns_name_label_encoder.sv
design/dnle_chk.sv
test/tb_top.sv
